// ----- hdl/sparse_polynomial_add_merge_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sparse polynomial merge core
// Clocked, reset-qualified wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_ADD_MERGE_CORE_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADD_MERGE_CORE_DEFINES_SVH

// same-cycle implication
`define SPADD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPADD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/spadd_pkg.sv -----
// ----------------------------------------------------------------------------
// spadd_pkg
// Widths, term layout and mode codes of the sparse polynomial merge core.
// ----------------------------------------------------------------------------
package spadd_pkg;

    localparam int MAX_TERMS = 16;
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    localparam int COEFF_W   = 16;
    localparam int EXPO_W    = 10;
    localparam int SUM_W     = COEFF_W + 1;
    localparam int TERM_W    = COEFF_W + EXPO_W;
    localparam int S_TDATA_W = ((TERM_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SUM_W + EXPO_W + 7) / 8) * 8;

    localparam logic [1:0] MODE_APPEND_A = 2'd0;
    localparam logic [1:0] MODE_APPEND_B = 2'd1;
    localparam logic [1:0] MODE_ADD      = 2'd2;
    localparam logic [1:0] MODE_CLEAR    = 2'd3;

    // coefficient in the low bits
    typedef struct packed {
        logic        [EXPO_W-1:0]  expo;
        logic signed [COEFF_W-1:0] coeff;
    } term_t;

endpackage

// ----- hdl/sparse_polynomial_add_merge_core.sv -----
// ----------------------------------------------------------------------------
// sparse_polynomial_add_merge_core
// Two term lists in block memories, merged on request into one sorted sum.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) carries commands: s_tuser selects append to list A,
//   append to list B, add, or clear; s_tdata holds the term to append.
//   An append to a full list is dropped. An add walks both lists from
//   their first entries and sends one result term on the master channel
//   (m_*) per merge step, highest exponent first, with m_tlast on the final
//   term. Two empty lists give a single transfer with m_tuser set and all
//   other fields zero. Each merge step reads both list memories at the
//   current positions, then compares and loads the output register.
//   The slave channel is not ready while an add is running. A stalled master
//   channel holds the output register and the merge waits for it.
//   Reset empties both lists; memory contents are not cleared.
// ----------------------------------------------------------------------------
`include "sparse_polynomial_add_merge_core_defines.svh"

module sparse_polynomial_add_merge_core
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [spadd_pkg::S_TDATA_W-1:0]  s_tdata,   // term_coeff, term_exponent
    input  logic [1:0]                       s_tuser,   // mode

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [spadd_pkg::M_TDATA_W-1:0]  m_tdata,   // sum_coeff, sum_exponent
    output logic                             m_tlast,   // last_term
    output logic                             m_tuser    // empty_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int CNT_W = spadd_pkg::CNT_W;
    localparam int IDX_W = spadd_pkg::IDX_W;

    spadd_pkg::term_t mem_a [spadd_pkg::MAX_TERMS];
    spadd_pkg::term_t mem_b [spadd_pkg::MAX_TERMS];
    spadd_pkg::term_t rd_a_reg;
    spadd_pkg::term_t rd_b_reg;
    spadd_pkg::term_t in_term;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_a_reg, count_a_next;
    logic [CNT_W-1:0] count_b_reg, count_b_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;

    logic                              out_valid_reg, out_valid_next;
    logic signed [spadd_pkg::SUM_W-1:0] out_coeff_reg, out_coeff_next;
    logic [spadd_pkg::EXPO_W-1:0]      out_expo_reg, out_expo_next;
    logic                              out_last_reg, out_last_next;
    logic                              out_empty_reg, out_empty_next;

    logic s_xfer;
    logic out_free;
    logic write_a;
    logic write_b;
    logic a_has;
    logic b_has;
    logic signed [spadd_pkg::SUM_W-1:0] a_ext;
    logic signed [spadd_pkg::SUM_W-1:0] b_ext;

    assign in_term  = spadd_pkg::term_t'(s_tdata[spadd_pkg::TERM_W-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign write_a  = s_xfer && (s_tuser == spadd_pkg::MODE_APPEND_A)
                      && (count_a_reg < CNT_W'(spadd_pkg::MAX_TERMS));
    assign write_b  = s_xfer && (s_tuser == spadd_pkg::MODE_APPEND_B)
                      && (count_b_reg < CNT_W'(spadd_pkg::MAX_TERMS));

    assign a_has = (i_reg < count_a_reg);
    assign b_has = (j_reg < count_b_reg);
    assign a_ext = {rd_a_reg.coeff[spadd_pkg::COEFF_W-1], rd_a_reg.coeff};
    assign b_ext = {rd_b_reg.coeff[spadd_pkg::COEFF_W-1], rd_b_reg.coeff};

    always_ff @(posedge clk)
    begin
        if (write_a)
        begin
            mem_a[count_a_reg[IDX_W-1:0]] <= in_term;
        end
        if (write_b)
        begin
            mem_b[count_b_reg[IDX_W-1:0]] <= in_term;
        end
        rd_a_reg <= mem_a[i_reg[IDX_W-1:0]];
        rd_b_reg <= mem_b[j_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_coeff_next = out_coeff_reg;
        out_expo_next  = out_expo_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    unique case (s_tuser)
                        spadd_pkg::MODE_APPEND_A:
                        begin
                            if (write_a)
                            begin
                                count_a_next = count_a_reg + CNT_W'(1);
                            end
                        end
                        spadd_pkg::MODE_APPEND_B:
                        begin
                            if (write_b)
                            begin
                                count_b_next = count_b_reg + CNT_W'(1);
                            end
                        end
                        spadd_pkg::MODE_ADD:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            state_next = ST_READ;
                        end
                        spadd_pkg::MODE_CLEAR:
                        begin
                            count_a_next = '0;
                            count_b_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_empty_next = 1'b0;
                    priority if (!a_has && !b_has)
                    begin
                        out_coeff_next = '0;
                        out_expo_next  = '0;
                        out_empty_next = 1'b1;
                    end
                    else if (a_has && b_has && (rd_a_reg.expo == rd_b_reg.expo))
                    begin
                        out_coeff_next = a_ext + b_ext;
                        out_expo_next  = rd_a_reg.expo;
                        i_next         = i_reg + CNT_W'(1);
                        j_next         = j_reg + CNT_W'(1);
                    end
                    else if (a_has && (!b_has || (rd_a_reg.expo > rd_b_reg.expo)))
                    begin
                        out_coeff_next = a_ext;
                        out_expo_next  = rd_a_reg.expo;
                        i_next         = i_reg + CNT_W'(1);
                    end
                    else
                    begin
                        out_coeff_next = b_ext;
                        out_expo_next  = rd_b_reg.expo;
                        j_next         = j_reg + CNT_W'(1);
                    end
                    out_last_next = !out_empty_next
                                    && (i_next >= count_a_reg) && (j_next >= count_b_reg);
                    if (out_empty_next || out_last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_coeff_reg <= out_coeff_next;
        out_expo_reg  <= out_expo_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(spadd_pkg::M_TDATA_W - spadd_pkg::SUM_W - spadd_pkg::EXPO_W){1'b0}},
                       out_expo_reg, out_coeff_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    `SPADD_ASSERT_NOW(a_count_bound, 1'b1,
        (count_a_reg <= CNT_W'(spadd_pkg::MAX_TERMS))
        && (count_b_reg <= CNT_W'(spadd_pkg::MAX_TERMS)),
        "list count exceeds capacity")
    `SPADD_ASSERT_NOW(a_walk_bound, state_reg != ST_IDLE,
        (i_reg <= count_a_reg) && (j_reg <= count_b_reg),
        "merge position passed end of list")
    `SPADD_ASSERT_NOW(a_empty_fields, m_tvalid && m_tuser,
        !m_tlast && (m_tdata == '0),
        "empty result carries nonzero fields")
    `SPADD_ASSERT_NEXT(a_emit_step, (state_reg == ST_EMIT) && out_free,
        m_tvalid && (state_reg != ST_EMIT),
        "merge step did not load output")

endmodule
